// File: design/swmin_pkg.sv
// Shared types and constants of the sliding window minimum block.
package swmin_pkg;

   localparam int SAMPLE_W = 32;
   localparam int LEN_W    = 9;

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(20);

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DELIVER
   } state_type;

endpackage

// File: design/swmin_store.sv
// Sample ring store: one write port, one read port with registered read data.
module swmin_store import swmin_pkg::*; #(
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  sample_type               wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output sample_type               rd_data
);

   sample_type mem [DEPTH];
   sample_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/sliding_window_minimum.sv
// Sliding window minimum: top level with sequencer, rescan logic and result register.
//
// Each request carries one signed Q16.16 sample; the block returns the minimum of the last
// window_len samples of the current series (the minimum so far while the series is still
// shorter than the window, or the running minimum of the whole series when window_len is 0),
// together with a flag that is high once the window is full. series_start begins a new
// series; the first request after reset always begins one. Samples live in a ring store of
// WINDOW_MAX entries with a single read port and registered read data; window lengths above
// WINDOW_MAX act as WINDOW_MAX. A request that only compares against the held minimum is
// accepted and then, once the result register is free, loads it. When the held minimum drops
// out of the window, or the window was shrunk below the current fill, the window of n entries
// is read back one entry per cycle through the store's read port, after which the result
// register is loaded. Ties go to the newest position. The result register lets a finished
// result wait on rsp_ready while the next request is accepted. The store needs no clearing
// pass after reset: the fill count keeps reads on written entries. Write window_len only
// while no request is in flight.
module sliding_window_minimum import swmin_pkg::*; #(
   parameter int WINDOW_MAX = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sample_type       req_sample,
   input  logic             req_series_start,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sample_type       rsp_window_min,
   output logic             rsp_window_full,
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data
);

   localparam int IDX_W = $clog2(WINDOW_MAX);
   localparam int CNT_W = $clog2(WINDOW_MAX + 2);
   localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int POS_W = CNT_W + 1;

   localparam logic [CMP_W-1:0] WMAX_CMP = CMP_W'(WINDOW_MAX);
   localparam logic [POS_W-1:0] WMAX_POS = POS_W'(WINDOW_MAX);
   localparam logic [CNT_W-1:0] FILL_TOP = CNT_W'(WINDOW_MAX + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_MAX - 1);

   // control state
   state_type        state_ff, state_in;
   logic [LEN_W-1:0] window_len_ff, window_len_in;
   logic [IDX_W-1:0] write_index_ff, write_index_in;
   logic [CNT_W-1:0] fill_count_ff, fill_count_in;
   sample_type       current_min_ff, current_min_in;
   logic [IDX_W-1:0] min_index_ff, min_index_in;
   logic             full_ff, full_in;
   logic [CNT_W-1:0] scan_left_ff, scan_left_in;
   logic             scan_first_ff, scan_first_in;
   logic             rd_valid_ff, rd_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload
   logic [IDX_W-1:0] scan_pos_ff, scan_pos_in;
   logic [IDX_W-1:0] rd_pos_ff, rd_pos_in;
   sample_type       rsp_window_min_ff, rsp_window_min_in;
   logic             rsp_window_full_ff, rsp_window_full_in;

   // sequencer outputs
   logic accept;
   logic rd_issue;
   logic deliver;
   logic rsp_free;

   // accept-path terms
   logic [CNT_W-1:0] fill_base;
   logic [CMP_W-1:0] len_ext;
   logic [CNT_W-1:0] win_n;
   logic [POS_W-1:0] leave_sum;
   logic [POS_W-1:0] start_sum;
   logic [IDX_W-1:0] leaving;
   logic [IDX_W-1:0] scan_start;
   logic             new_le;
   logic             need_scan;
   sample_type       rd_data;

   swmin_store #(
      .DEPTH (WINDOW_MAX)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (write_index_ff),
      .wr_data (req_sample),
      .rd_en   (rd_issue),
      .rd_addr (scan_pos_ff),
      .rd_data (rd_data)
   );

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Window geometry for the request at the port: clamp the length, locate the entry that
   // leaves and the oldest entry of the window.
   always_comb begin
      fill_base = req_series_start ? '0 : fill_count_ff;
      len_ext   = CMP_W'(window_len_ff);
      win_n     = (len_ext > WMAX_CMP) ? CNT_W'(WMAX_CMP) : CNT_W'(len_ext);
      new_le    = (req_sample <= current_min_ff);

      leave_sum = POS_W'(write_index_ff) + WMAX_POS - POS_W'(win_n);
      leaving   = (leave_sum >= WMAX_POS) ? IDX_W'(leave_sum - WMAX_POS) : IDX_W'(leave_sum);

      start_sum  = POS_W'(write_index_ff) + WMAX_POS + POS_W'(1) - POS_W'(win_n);
      scan_start = (start_sum >= WMAX_POS) ? IDX_W'(start_sum - WMAX_POS) : IDX_W'(start_sum);

      // A full window must be read back when the minimum drops out or the window shrank.
      need_scan = (fill_base != '0) && (win_n != '0) && (fill_base >= win_n) &&
                  ((fill_base > win_n) || (min_index_ff == leaving));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = need_scan ? ST_SCAN : ST_DELIVER;
            end
         end
         ST_SCAN: begin
            if ((scan_left_ff == '0) && rd_valid_ff) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      rd_issue  = 1'b0;
      deliver   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SCAN: begin
            rd_issue = (scan_left_ff != '0);
         end
         ST_DELIVER: begin
            deliver = rsp_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      accept = req_valid && req_ready;
   end

   // datapath next values
   always_comb begin
      window_len_in      = csr_wr_en ? csr_wr_data : window_len_ff;
      write_index_in     = write_index_ff;
      fill_count_in      = fill_count_ff;
      current_min_in     = current_min_ff;
      min_index_in       = min_index_ff;
      full_in            = full_ff;
      scan_left_in       = scan_left_ff;
      scan_first_in      = scan_first_ff;
      scan_pos_in        = scan_pos_ff;
      rd_valid_in        = rd_issue;
      rd_pos_in          = scan_pos_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_window_min_in  = rsp_window_min_ff;
      rsp_window_full_in = rsp_window_full_ff;

      if (accept) begin
         write_index_in = (write_index_ff == IDX_LAST) ? '0 : write_index_ff + IDX_W'(1);
         if (fill_base == '0) begin
            // first sample of a series
            current_min_in = req_sample;
            min_index_in   = write_index_ff;
            fill_count_in  = CNT_W'(1);
            full_in        = (win_n == CNT_W'(1));
         end else if (win_n == '0) begin
            // running minimum; hold the count once past capacity
            if (new_le) begin
               current_min_in = req_sample;
               min_index_in   = write_index_ff;
            end
            fill_count_in = (fill_base < FILL_TOP) ? fill_base + CNT_W'(1) : fill_base;
            full_in       = 1'b0;
         end else if (fill_base < win_n) begin
            // still filling
            if (new_le) begin
               current_min_in = req_sample;
               min_index_in   = write_index_ff;
            end
            fill_count_in = fill_base + CNT_W'(1);
            full_in       = ((fill_base + CNT_W'(1)) >= win_n);
         end else begin
            fill_count_in = win_n;
            full_in       = 1'b1;
            if (need_scan) begin
               scan_pos_in   = scan_start;
               scan_left_in  = win_n;
               scan_first_in = 1'b1;
            end else if (new_le) begin
               current_min_in = req_sample;
               min_index_in   = write_index_ff;
            end
         end
      end

      // issue one read a cycle, oldest entry first
      if (rd_issue) begin
         scan_pos_in  = (scan_pos_ff == IDX_LAST) ? '0 : scan_pos_ff + IDX_W'(1);
         scan_left_in = scan_left_ff - CNT_W'(1);
      end

      // fold returning data; later entries win ties
      if (rd_valid_ff) begin
         scan_first_in = 1'b0;
         if (scan_first_ff || (rd_data <= current_min_ff)) begin
            current_min_in = rd_data;
            min_index_in   = rd_pos_ff;
         end
      end

      if (deliver) begin
         rsp_valid_in       = 1'b1;
         rsp_window_min_in  = current_min_ff;
         rsp_window_full_in = full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         window_len_ff  <= LEN_RESET;
         write_index_ff <= '0;
         fill_count_ff  <= '0;
         current_min_ff <= '0;
         min_index_ff   <= '0;
         full_ff        <= 1'b0;
         scan_left_ff   <= '0;
         scan_first_ff  <= 1'b0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         window_len_ff  <= window_len_in;
         write_index_ff <= write_index_in;
         fill_count_ff  <= fill_count_in;
         current_min_ff <= current_min_in;
         min_index_ff   <= min_index_in;
         full_ff        <= full_in;
         scan_left_ff   <= scan_left_in;
         scan_first_ff  <= scan_first_in;
         rd_valid_ff    <= rd_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_pos_ff        <= scan_pos_in;
      rd_pos_ff          <= rd_pos_in;
      rsp_window_min_ff  <= rsp_window_min_in;
      rsp_window_full_ff <= rsp_window_full_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_window_min  = rsp_window_min_ff;
   assign rsp_window_full = rsp_window_full_ff;

   // The fill count never runs past one beyond the store's capacity.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= FILL_TOP)
      else $error("fill count beyond capacity");

   // A full flag is never reported in running-minimum mode.
   a_full_needs_window: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_window_full) |-> (window_len_ff != '0))
      else $error("window_full set with window_len zero");

   // An accepted request always leaves the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("request accepted without starting work");

   // Read data returns only while the rescan is running.
   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == ST_SCAN))
      else $error("store read data outside rescan");

endmodule
